// ===== rtl/tdpc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpc_pkg: shared constants and types of the trial-division prime counter
// defaults, field widths and the command/status bundles between control and data
// ----------------------------------------------------------------------------
package tdpc_pkg;

    localparam int NUM_WIDTH_DEF = 32;       // default internal number width
    localparam int CAND_W        = 32;       // candidate field width
    localparam int SEED_W        = 32;       // root_seed register width
    localparam int RES_W         = 32;       // root_used / prime_count widths
    localparam int S_TDATA_W     = 32;       // candidate
    localparam int S_TUSER_W     = 1;        // restart
    localparam int M_TDATA_W     = 72;       // is_prime, root_used, prime_count, pad

    localparam logic [SEED_W-1:0] ROOT_SEED_RESET = 32'd65535;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;        // capture candidate, apply restart
        logic div_start;   // launch the divider
        logic div_trial;   // divisor is the trial divisor, else the root
        logic root_upd;    // store babylonian step, set up trial loop
        logic j_step;      // advance trial divisor by two
        logic composite;   // divisor found
        logic finish;      // update count, load output register
    } tdpc_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic div_done;    // divider result ready this cycle
        logic rem_zero;    // divider remainder is zero
        logic j_gt_limit;  // trial divisor beyond the limit
        logic j_last;      // no further odd divisor within the limit
        logic out_free;    // output register can take a result
    } tdpc_sts_t;

endpackage
`default_nettype wire

// ===== rtl/tdpc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpc_div: iterative restoring divider
// one quotient bit per cycle, done pulses after NUM_WIDTH steps
// ----------------------------------------------------------------------------
module tdpc_div #(
    parameter int NUM_WIDTH = tdpc_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [NUM_WIDTH-1:0] dividend,
    input  wire logic [NUM_WIDTH-1:0] divisor,
    output logic                      done,
    output logic [NUM_WIDTH-1:0]      quotient,
    output logic [NUM_WIDTH-1:0]      remainder
);

    localparam int CNT_W = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] rem_reg;
    logic [NUM_WIDTH-1:0] quo_reg;
    logic [NUM_WIDTH-1:0] dvs_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [NUM_WIDTH:0]   rem_shift;
    logic [NUM_WIDTH+1:0] diff;
    logic [NUM_WIDTH-1:0] rem_next;
    logic [NUM_WIDTH-1:0] quo_next;

    assign rem_shift = {rem_reg, quo_reg[NUM_WIDTH-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};

    always_comb
    begin
        if (diff[NUM_WIDTH+1])
        begin
            rem_next = rem_shift[NUM_WIDTH-1:0];
            quo_next = {quo_reg[NUM_WIDTH-2:0], 1'b0};
        end
        else
        begin
            rem_next = diff[NUM_WIDTH-1:0];
            quo_next = {quo_reg[NUM_WIDTH-2:0], 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_WIDTH);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ===== rtl/tdpc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpc_datapath: number registers, divider and output register
// holds root estimate, trial divisor, limit and prime count
// ----------------------------------------------------------------------------
module tdpc_datapath #(
    parameter int NUM_WIDTH = tdpc_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [tdpc_pkg::SEED_W-1:0]    cfg_data,
    input  wire logic [tdpc_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [tdpc_pkg::S_TUSER_W-1:0] s_tuser,
    input  wire tdpc_pkg::tdpc_cmd_t            cmd,
    output tdpc_pkg::tdpc_sts_t                 sts,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [tdpc_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int NW = NUM_WIDTH;
    localparam int RW = tdpc_pkg::RES_W;
    localparam logic [NW-1:0] ROOT_RESET = NW'(tdpc_pkg::ROOT_SEED_RESET);
    localparam logic [NW-1:0] ONE = {{(NW-1){1'b0}}, 1'b1};
    localparam logic [NW-1:0] TWO = {{(NW-2){1'b0}}, 2'b10};
    localparam logic [NW-1:0] THREE = {{(NW-2){1'b0}}, 2'b11};

    logic [tdpc_pkg::SEED_W-1:0] seed_reg;
    logic [NW-1:0] n_reg;
    logic [NW-1:0] root_reg;
    logic [NW-1:0] limit_reg;
    logic [NW-1:0] j_reg;
    logic [NW-1:0] count_reg;
    logic          prime_reg;
    logic          out_valid_reg;
    logic          out_prime_reg;
    logic [RW-1:0] out_root_reg;
    logic [RW-1:0] out_count_reg;

    logic [NW+31:0] cand_ext;
    logic [NW+31:0] seed_ext;
    logic [NW-1:0]  cand_n;
    logic [NW-1:0]  seed_n;
    logic [NW-1:0]  r_eff;
    logic [NW-1:0]  root_next;
    logic [NW-1:0]  limit_next;
    logic [NW-1:0]  count_next;
    logic [NW+31:0] root_out_ext;
    logic [NW+31:0] count_out_ext;
    logic [NW-1:0]  div_divisor;
    logic           div_done;
    logic [NW-1:0]  div_quo;
    logic [NW-1:0]  div_rem;

    // width adaption to and from the 32-bit fields
    assign cand_ext      = {{NW{1'b0}}, s_tdata};
    assign seed_ext      = {{NW{1'b0}}, seed_reg};
    assign cand_n        = cand_ext[NW-1:0];
    assign seed_n        = seed_ext[NW-1:0];
    assign root_out_ext  = {32'd0, root_reg};
    assign count_out_ext = {32'd0, count_next};

    // a zero estimate divides as one
    assign r_eff       = (root_reg == '0) ? ONE : root_reg;
    assign div_divisor = cmd.div_trial ? j_reg : r_eff;

    tdpc_div #(
        .NUM_WIDTH (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (n_reg),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // babylonian step without overflow, then the trial limit
    assign root_next  = (r_eff >> 1) + (div_quo >> 1)
                      + {{(NW-1){1'b0}}, r_eff[0] & div_quo[0]};
    assign limit_next = (n_reg != '0 && n_reg < root_next) ? n_reg : root_next;
    assign count_next = (prime_reg && count_reg != '1) ? count_reg + ONE : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= tdpc_pkg::ROOT_SEED_RESET;
            root_reg      <= ROOT_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                seed_reg <= cfg_data;
            if (cmd.load && s_tuser[0])
            begin
                root_reg  <= seed_n;
                count_reg <= '0;
            end
            else if (cmd.root_upd)
                root_reg <= root_next;
            else if (cmd.finish)
                count_reg <= count_next;
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            n_reg <= cand_n;
        if (cmd.root_upd)
        begin
            limit_reg <= limit_next;
            j_reg     <= THREE;
            prime_reg <= 1'b1;
        end
        else
        begin
            if (cmd.j_step)
                j_reg <= j_reg + TWO;
            if (cmd.composite)
                prime_reg <= 1'b0;
        end
        if (cmd.finish)
        begin
            out_prime_reg <= prime_reg;
            out_root_reg  <= root_out_ext[RW-1:0];
            out_count_reg <= count_out_ext[RW-1:0];
        end
    end

    assign sts.div_done   = div_done;
    assign sts.rem_zero   = (div_rem == '0);
    assign sts.j_gt_limit = (j_reg > limit_reg);
    assign sts.j_last     = ((limit_reg - j_reg) < TWO);
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_count_reg, out_root_reg, out_prime_reg};

endmodule
`default_nettype wire

// ===== rtl/tdpc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpc_ctrl: sequencer of the prime counter
// root step, then one trial division per odd divisor, then result hand-off
// ----------------------------------------------------------------------------
module tdpc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire tdpc_pkg::tdpc_sts_t sts,
    output tdpc_pkg::tdpc_cmd_t      cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_ROOT_UPD,
        ST_CHECK,
        ST_TRIAL,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_ROOT_GO;
                end
            end
            ST_ROOT_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (sts.div_done)
                    state_next = ST_ROOT_UPD;
            end
            ST_ROOT_UPD:
            begin
                cmd.root_upd = 1'b1;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.div_trial = 1'b1;
                if (sts.j_gt_limit)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_TRIAL;
                end
            end
            ST_TRIAL:
            begin
                cmd.div_trial = 1'b1;
                if (sts.div_done)
                begin
                    if (sts.rem_zero)
                    begin
                        cmd.composite = 1'b1;
                        state_next    = ST_FINISH;
                    end
                    else if (sts.j_last)
                        state_next = ST_FINISH;
                    else
                    begin
                        cmd.j_step = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

// ===== rtl/trial_division_prime_counter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_counter: primality test by odd trial division
// babylonian root update per candidate, saturating count of primes
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  ---------+-----------+--------------------------------------------------
//  cfg      | in        | cfg_data: root_seed (32)
//  s_axis   | in        | tdata: candidate (32); tuser: restart (1)
//  m_axis   | out       | tdata: is_prime (1), root_used (32), prime_count (32)
//
//  one item at a time; the shared iterative divider sets the pace. an item
//  takes one division for the root step plus one for each odd divisor tried,
//  up to (root - 1) / 2 divisors. reset is asynchronous, active low; the seed
//  returns to 65535 and the count to zero. a stalled result holds in the
//  output register, the next item is taken meanwhile and waits at its end
//  for the register to free up.
// ----------------------------------------------------------------------------
module trial_division_prime_counter #(
    parameter int NUM_WIDTH = tdpc_pkg::NUM_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write, always ready
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tdpc_pkg::SEED_W-1:0]    cfg_data,   // [31:0] root_seed
    // candidate items
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [tdpc_pkg::S_TDATA_W-1:0] s_tdata,    // [31:0] candidate
    input  wire logic [tdpc_pkg::S_TUSER_W-1:0] s_tuser,    // [0] restart
    // result items
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [0] is_prime, [32:1] root_used, [64:33] prime_count, [71:65] zero
    output logic [tdpc_pkg::M_TDATA_W-1:0]      m_tdata
);

    tdpc_pkg::tdpc_cmd_t cmd;
    tdpc_pkg::tdpc_sts_t sts;

    // seed register takes a write every cycle
    assign cfg_ready = 1'b1;

    // sequencer: accepts items and steps the datapath
    tdpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // numbers, divider and output register
    tdpc_datapath #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

// ===== rtl/tdpc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdpc_checker: port-level checks of the prime counter
// item accounting and output hold under stall
// ----------------------------------------------------------------------------
module tdpc_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [tdpc_pkg::M_TDATA_W-1:0] m_tdata
);

    logic       s_acc;
    logic       m_acc;
    logic [1:0] pend_reg;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    // items taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 2'd0;
        else if (s_acc && !m_acc)
            pend_reg <= pend_reg + 2'd1;
        else if (m_acc && !s_acc)
            pend_reg <= pend_reg - 2'd1;
    end

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> !s_tready)
        else $error("input ready right after an accepted item");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != 2'd0)
        else $error("result offered with no item pending");

    a_bounded_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> pend_reg <= 2'd1)
        else $error("input ready with two results outstanding");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind trial_division_prime_counter tdpc_checker u_tdpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

// ===== bench/prime_count_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_count_checker: result checker for the trial-division prime counter
// follows seed writes and accepted candidates, predicts each result item and
// compares it field by field with the items leaving the block
// ----------------------------------------------------------------------------
module prime_count_checker
    import tdpc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [SEED_W-1:0]      cfg_data,    // [31:0] root_seed
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,     // [31:0] candidate
    input  logic [S_TUSER_W-1:0]   s_tuser,     // [0] restart
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] is_prime, [32:1] root_used, [64:33] prime_count, [71:65] zero
    input  logic [M_TDATA_W-1:0]   m_tdata,
    output int                     mismatches,
    output int                     outstanding
);

    typedef struct packed {
        logic              is_prime;
        logic [RES_W-1:0]  root_used;
        logic [RES_W-1:0]  prime_count;
    } verdict_t;

    logic [SEED_W-1:0] seed_reg;
    logic [RES_W-1:0]  root_est;
    logic [RES_W-1:0]  found_cnt;
    verdict_t          pending_verdicts[$];

    // one babylonian step on the root, then odd trial division up to it
    function automatic verdict_t test_candidate(input logic [CAND_W-1:0] n,
                                                input logic restart);
        logic [RES_W-1:0] r;
        logic [RES_W-1:0] q;
        longint unsigned  lim;
        longint unsigned  j;
        verdict_t         v;
        if (restart)
        begin
            root_est  = seed_reg;
            found_cnt = '0;
        end
        r = (root_est == '0) ? RES_W'(1) : root_est;
        q = n / r;
        r = (r >> 1) + (q >> 1) + (r & q & RES_W'(1));
        root_est = r;
        // no divisor above a nonzero candidate can divide it
        lim = r;
        if (n != '0 && n < lim)
            lim = n;
        v.is_prime = 1'b1;
        for (j = 3; j <= lim; j += 2)
        begin
            if (n % j == 0)
            begin
                v.is_prime = 1'b0;
                break;
            end
        end
        if (v.is_prime && found_cnt != '1)
            found_cnt = found_cnt + 1'b1;
        v.root_used   = r;
        v.prime_count = found_cnt;
        return v;
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            seed_reg  = ROOT_SEED_RESET;
            root_est  = ROOT_SEED_RESET;
            found_cnt = '0;
            pending_verdicts.delete();
            mismatches  = 0;
            outstanding = 0;
        end
        else
        begin
            // results first, so an item never meets its own expectation early
            if (m_tvalid && m_tready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("result item 0x%0h with no candidate waiting", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    check_field("is_prime", want.is_prime, m_tdata[0]);
                    check_field("root_used", want.root_used, m_tdata[RES_W:1]);
                    check_field("prime_count", want.prime_count,
                                m_tdata[2*RES_W:RES_W+1]);
                    check_field("pad", 0, m_tdata[M_TDATA_W-1:2*RES_W+1]);
                end
            end
            if (cfg_valid && cfg_ready)
                seed_reg = cfg_data;
            if (s_tvalid && s_tready)
                pending_verdicts.push_back(test_candidate(s_tdata, s_tuser[0]));
            outstanding = pending_verdicts.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the trial-division prime counter
// drives seed writes and candidate items with random gaps and backpressure,
// a side checker predicts and compares every result item
// ----------------------------------------------------------------------------
module tb;
    import tdpc_pkg::*;

    // run-length limit above the slowest legal run, with a wide margin
    localparam int LIMIT_CYCLES = 10_000_000;
    // settle time after the last result
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_PER_PHASE = 30;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [SEED_W-1:0]     cfg_data = '0;        // [31:0] root_seed
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;         // [31:0] candidate
    logic [S_TUSER_W-1:0]  s_tuser = '0;         // [0] restart
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] is_prime, [32:1] root_used, [64:33] prime_count, [71:65] zero
    logic [M_TDATA_W-1:0]  m_tdata;

    int  mismatches;
    int  outstanding;
    int  cycle_count = 0;
    // when set, neither side idles: a long stretch at full pressure
    bit  calm = 1'b0;

    always #10 clk = ~clk;

    trial_division_prime_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    prime_count_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // hard stop in case the block hangs or drops a result
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("trial_division_prime_counter verification failed");
            $finish;
        end
    end

    // receiver stalls about one cycle in ten, never while calm
    always @(negedge clk)
        m_tready <= calm || ($urandom_range(0, 99) >= 10);

    // present one candidate item from a falling edge, return at the falling
    // edge after it was taken; valid stays up for a following item unless a random gap drops it
    task automatic offer_candidate(input logic [S_TDATA_W-1:0] n, input logic restart);
        s_tvalid <= 1'b1;
        s_tdata  <= n;
        s_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        // random sender gap, never while calm
        if (!calm && $urandom_range(0, 99) < 10)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    // stop sending and wait until every result item has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // seed writes only happen with the block idle
    task automatic load_root_seed(input logic [SEED_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [SEED_W-1:0]    seed;
        logic [S_TDATA_W-1:0] n;
        logic                 restart;
        bit                   mid_ok;
        int unsigned          roll;
        int unsigned          factor;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---------------- directed: reset seed of 65535 ----------------
        offer_candidate(32'd0, 1'b0);              // zero, divided by three
        offer_candidate(32'd7, 1'b0);              // divisor equal to the candidate
        offer_candidate(32'd1, 1'b0);
        offer_candidate(32'd2, 1'b0);              // even value, no odd divisor
        offer_candidate(32'd9, 1'b0);
        offer_candidate(32'hFFFF_FFFF, 1'b0);      // all ones, multiple of three
        offer_candidate(32'h8000_0001, 1'b0);
        offer_candidate(32'hFFFF_FFFC, 1'b0);
        offer_candidate(32'd251, 1'b1);            // small prime, root above it
        drain_results();

        // ---------------- directed: smallest seed ----------------
        load_root_seed(32'd1);
        offer_candidate(32'd0, 1'b1);              // step gives a zero root
        offer_candidate(32'd0, 1'b0);              // zero root forced to one
        offer_candidate(32'd5, 1'b0);
        offer_candidate(32'd97, 1'b0);             // prime with root below it
        offer_candidate(32'hFFFF_FFFF, 1'b1);
        offer_candidate(32'd11, 1'b0);
        drain_results();

        // ---------------- directed: largest seed ----------------
        load_root_seed(32'hFFFF_FFFF);
        offer_candidate(32'd0, 1'b1);              // huge root, zero candidate
        offer_candidate(32'hFFFF_FFFF, 1'b1);      // step sum near the top
        offer_candidate(32'd2, 1'b0);
        offer_candidate(32'd4, 1'b0);
        offer_candidate(32'd3, 1'b0);
        drain_results();

        // ---------------- random phases ----------------
        // trial division cost follows min(candidate, root); large candidates
        // always carry a small odd factor, mid-range ones come with a restart
        // only under a seed near their square root
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0, 3:    seed = $urandom_range(1024, 256);
                1:       seed = 32'd1;
                default: seed = 32'hFFFF_FFFF;
            endcase
            mid_ok = (seed >= 256 && seed <= 1024);
            calm   = (ph == 1);
            load_root_seed(seed);
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                roll    = $urandom_range(0, 99);
                restart = ($urandom_range(0, 99) < 15);
                if (mid_ok && roll < 15)
                begin
                    n       = $urandom_range(200000, 1000);
                    restart = 1'b1;
                end
                else if (roll < 45)
                begin
                    case ($urandom_range(0, 4))
                        0:       factor = 3;
                        1:       factor = 5;
                        2:       factor = 7;
                        3:       factor = 9;
                        default: factor = 15;
                    endcase
                    n = ($urandom / factor) * factor;
                end
                else
                    n = $urandom_range(255, 0);
                offer_candidate(n, restart);
            end
            drain_results();
        end
        calm = 1'b0;

        if (mismatches == 0)
            $display("trial_division_prime_counter verification clean");
        else
            $display("trial_division_prime_counter verification failed");
        $finish;
    end

endmodule
